### design/act_pkg.sv
// ============================================================================
// act_pkg: shared types and constants for the tilt angle pipeline
// Vector and angle word types, the arctangent table in 1/65536 degree and the
// angle-to-output conversion with clamping.
// ============================================================================
`default_nettype none

package act_pkg;

    localparam int VEC_W      = 32;
    localparam int ANG_W      = 26;
    localparam int GUARD_BITS = 12;
    localparam int ATAN_N     = 24;
    localparam int PROD_W     = 46;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;

    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam t_ang        HALF_TURN    = 26'sd11796480;
    localparam t_ang        ROLL_LIMIT   = 26'sd23040;
    localparam t_ang        PITCH_LIMIT  = 26'sd11520;

    // atan(2^-i), 1/65536 degree, rounded to nearest
    localparam logic [21:0] ATAN_Q16 [ATAN_N] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    // 1/65536 degree to 1/128 degree, round half up, clamp to +/- limit
    function automatic t_ang to_out_units(input t_ang a, input t_ang limit);
        logic signed [ANG_W:0] sum;
        logic signed [ANG_W:0] quo;
        logic signed [ANG_W:0] lim;
        t_ang                  res;
        sum = {a[ANG_W-1], a} + (ANG_W+1)'(256);
        quo = sum >>> 9;
        lim = {limit[ANG_W-1], limit};
        res = t_ang'(quo);
        if (quo > lim) begin
            res = limit;
        end else if (quo < -lim) begin
            res = -limit;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/act_cordic_stage.sv
// ============================================================================
// act_cordic_stage: one registered vectoring micro-rotation
// Turns the vector towards the x axis by atan(2^-SHIFT) and accumulates the
// angle; the valid bit travels with the data.
// ============================================================================
`default_nettype none

module act_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  act_pkg::t_vec      i_x,
    input  act_pkg::t_vec      i_y,
    input  act_pkg::t_ang      i_ang,
    output logic               o_valid,
    output act_pkg::t_vec      o_x,
    output act_pkg::t_vec      o_y,
    output act_pkg::t_ang      o_ang
);

    localparam act_pkg::t_ang STEP_ANGLE =
        act_pkg::t_ang'({1'b0, act_pkg::ATAN_Q16[SHIFT]});

    logic          r_valid;
    act_pkg::t_vec r_x;
    act_pkg::t_vec r_y;
    act_pkg::t_ang r_ang;
    act_pkg::t_vec n_x;
    act_pkg::t_vec n_y;
    act_pkg::t_ang n_ang;
    act_pkg::t_vec dx;
    act_pkg::t_vec dy;

    always_comb begin
        dx = i_y >>> SHIFT;
        dy = i_x >>> SHIFT;
        if (!i_y[act_pkg::VEC_W-1]) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_ang = i_ang + STEP_ANGLE;
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_ang = i_ang - STEP_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_ang <= n_ang;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_ang   = r_ang;

endmodule

`default_nettype wire

### design/accel_tilt_angles.sv
// ============================================================================
// accel_tilt_angles: roll and pitch from one three-axis accelerometer sample
// Roll = atan2(y, z) and pitch = atan2(-x, |(y, z)|) in 1/128 degree, by two
// pipelined vectoring CORDIC passes with a gain correction between them.
// ============================================================================
// Takes one sample per clock: a transaction is accepted whenever start is
// high, and busy is always low. Each result appears on o_roll_angle and
// o_pitch_angle for one cycle with o_result_valid high, once its sample has
// passed the input register (which loads at the edge that accepted the
// sample), then one register per micro-rotation in each pass, two for the
// gain multiply and one for the output.
// The receiver cannot hold results off and none is needed.
`default_nettype none

module accel_tilt_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  signed [15:0] i_accel_x,
    input  wire  signed [15:0] i_accel_y,
    input  wire  signed [15:0] i_accel_z,
    output logic               o_result_valid,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle
);

    // input stage
    logic               r_v0;
    act_pkg::t_vec      r_x0;
    act_pkg::t_vec      r_y0;
    act_pkg::t_ang      r_a0;
    act_pkg::t_vec      n_x0;
    act_pkg::t_vec      n_y0;
    act_pkg::t_ang      n_a0;
    act_pkg::t_vec      vz;
    act_pkg::t_vec      vy;

    // pass one sideband
    logic signed [15:0] r_ax_p1 [CORDIC_STEPS+1];
    logic               r_zr_p1 [CORDIC_STEPS+1];

    logic               w1_v [CORDIC_STEPS+1];
    act_pkg::t_vec      w1_x [CORDIC_STEPS+1];
    act_pkg::t_vec      w1_y [CORDIC_STEPS+1];
    act_pkg::t_ang      w1_a [CORDIC_STEPS+1];

    // gain correction stages
    logic                       r_v_m1;
    logic [act_pkg::PROD_W-1:0] r_prod;
    logic signed [15:0]         r_roll_m1;
    logic signed [15:0]         r_ax_m1;
    logic [act_pkg::PROD_W-1:0] n_prod;
    act_pkg::t_ang              n_roll_a;
    logic [act_pkg::PROD_W-1:0] prod_rnd;
    logic signed [16:0]         neg_x;

    logic               r_v_m2;
    act_pkg::t_vec      r_x_m2;
    act_pkg::t_vec      r_y_m2;
    act_pkg::t_vec      n_x_m2;
    act_pkg::t_vec      n_y_m2;

    // pass two sideband
    logic signed [15:0] r_roll_p2 [CORDIC_STEPS+1];
    logic               r_zp_p2   [CORDIC_STEPS+1];

    logic               w2_v [CORDIC_STEPS+1];
    act_pkg::t_vec      w2_x [CORDIC_STEPS+1];
    act_pkg::t_vec      w2_y [CORDIC_STEPS+1];
    act_pkg::t_ang      w2_a [CORDIC_STEPS+1];

    // output stage
    logic               r_v_out;
    logic signed [15:0] r_roll_out;
    logic signed [14:0] r_pitch_out;
    act_pkg::t_ang      n_pitch_a;

    assign busy = 1'b0;

    // prepare roll vector, turn by half a turn for negative z
    always_comb begin
        vz   = {{4{i_accel_z[15]}}, i_accel_z, {act_pkg::GUARD_BITS{1'b0}}};
        vy   = {{4{i_accel_y[15]}}, i_accel_y, {act_pkg::GUARD_BITS{1'b0}}};
        n_x0 = vz;
        n_y0 = vy;
        n_a0 = '0;
        if (i_accel_z[15]) begin
            n_x0 = -vz;
            n_y0 = -vy;
            n_a0 = i_accel_y[15] ? -act_pkg::HALF_TURN : act_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_a0       <= n_a0;
        r_ax_p1[0] <= i_accel_x;
        r_zr_p1[0] <= (i_accel_y == 16'sd0) && (i_accel_z == 16'sd0);
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            r_ax_p1[k] <= r_ax_p1[k-1];
            r_zr_p1[k] <= r_zr_p1[k-1];
        end
    end

    assign w1_v[0] = r_v0;
    assign w1_x[0] = r_x0;
    assign w1_y[0] = r_y0;
    assign w1_a[0] = r_a0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_pass1
        act_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w1_v[g]),
            .i_x     (w1_x[g]),
            .i_y     (w1_y[g]),
            .i_ang   (w1_a[g]),
            .o_valid (w1_v[g+1]),
            .o_x     (w1_x[g+1]),
            .o_y     (w1_y[g+1]),
            .o_ang   (w1_a[g+1])
        );
    end

    // gain multiply and roll conversion
    always_comb begin
        n_prod   = act_pkg::PROD_W'(w1_x[CORDIC_STEPS][29:0])
                 * act_pkg::PROD_W'(act_pkg::INV_GAIN_Q16);
        n_roll_a = act_pkg::to_out_units(w1_a[CORDIC_STEPS], act_pkg::ROLL_LIMIT);
        if (r_zr_p1[CORDIC_STEPS]) begin
            n_prod   = '0;
            n_roll_a = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_m1 <= 1'b0;
            r_v_m2 <= 1'b0;
        end else begin
            r_v_m1 <= w1_v[CORDIC_STEPS];
            r_v_m2 <= r_v_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= n_prod;
        r_roll_m1 <= n_roll_a[15:0];
        r_ax_m1   <= r_ax_p1[CORDIC_STEPS];
    end

    // round corrected magnitude, form -x in a wide word
    always_comb begin
        prod_rnd = r_prod + act_pkg::PROD_W'(32768);
        neg_x    = -{r_ax_m1[15], r_ax_m1};
        n_x_m2   = act_pkg::t_vec'({2'b00, prod_rnd[act_pkg::PROD_W-1:16]});
        n_y_m2   = {{3{neg_x[16]}}, neg_x, {act_pkg::GUARD_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_x_m2       <= n_x_m2;
        r_y_m2       <= n_y_m2;
        r_roll_p2[0] <= r_roll_m1;
        r_zp_p2[0]   <= (n_x_m2 == '0) && (r_ax_m1 == 16'sd0);
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            r_roll_p2[k] <= r_roll_p2[k-1];
            r_zp_p2[k]   <= r_zp_p2[k-1];
        end
    end

    assign w2_v[0] = r_v_m2;
    assign w2_x[0] = r_x_m2;
    assign w2_y[0] = r_y_m2;
    assign w2_a[0] = '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_pass2
        act_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w2_v[g]),
            .i_x     (w2_x[g]),
            .i_y     (w2_y[g]),
            .i_ang   (w2_a[g]),
            .o_valid (w2_v[g+1]),
            .o_x     (w2_x[g+1]),
            .o_y     (w2_y[g+1]),
            .o_ang   (w2_a[g+1])
        );
    end

    // pitch conversion and output register
    always_comb begin
        n_pitch_a = act_pkg::to_out_units(w2_a[CORDIC_STEPS], act_pkg::PITCH_LIMIT);
        if (r_zp_p2[CORDIC_STEPS]) begin
            n_pitch_a = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_out <= 1'b0;
        end else begin
            r_v_out <= w2_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_roll_out  <= r_roll_p2[CORDIC_STEPS];
        r_pitch_out <= n_pitch_a[14:0];
    end

    assign o_result_valid = r_v_out;
    assign o_roll_angle   = r_roll_out;
    assign o_pitch_angle  = r_pitch_out;

    // unused bits of the final vectors
    logic unused_ok;
    assign unused_ok = ^{w1_y[CORDIC_STEPS], w1_x[CORDIC_STEPS][31:30],
                         w2_x[CORDIC_STEPS], w2_y[CORDIC_STEPS]};

endmodule

`default_nettype wire
